// ----- rtl/lkv_pkg.sv -----
// Package for the LRU key-value cache: sizes, command codes and the structs
// passed between the request front end and the cache back end.
// No dependencies.
package lkv_pkg;

  localparam int unsigned MaxEntries = 8;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned ValueBits  = 64;
  localparam int unsigned LimitBits  = 4;
  localparam int unsigned IdxBits    = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CountBits  = $clog2(MaxEntries + 1);

  // Both decoupling queues hold two transactions.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [LimitBits-1:0] LimitReset = 4'd8;

  typedef enum logic {
    CmdLookup = 1'b0,
    CmdStore  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [ValueBits-1:0] value;
  } rsp_t;

  typedef struct packed {
    logic [MaxEntries-1:0] valid;
    logic [CountBits-1:0]  used;
  } status_t;

endpackage

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: entry limit register, request
// front end and cache back end.
// Depends on lkv_pkg, lkv_front and lkv_back.

// A small fully associative cache of eight 64-bit key/value pairs with
// least-recently-used replacement. Each request is a lookup or a store and
// produces exactly one result: hit tells whether the key was present, and
// read_value_o carries the stored value on a lookup hit and zero otherwise.
// Requests enter a two-deep queue on the push/full side; the back end takes
// one request per clock while the result queue has room, compares the key
// against all eight tags in parallel and updates the recency ranks in the
// same cycle, so the sustained rate is one request per cycle when the reader
// keeps up. A pushed request is registered in the input queue and its result
// in a two-deep queue on the empty/pop side, so a stalled reader holds up the
// input side only once both queues have filled. The entry limit (reset 8)
// sets how many entries fill before eviction starts; zero acts as one and
// values above eight act as eight. Lowering it never drops entries. The user
// must write it only while no transaction is in flight; no check enforces it.
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::LimitBits-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          command_i,
  input  logic [lkv_pkg::KeyBits-1:0]   key_i,
  input  logic [lkv_pkg::ValueBits-1:0] write_value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit_o,
  output logic [lkv_pkg::ValueBits-1:0] read_value_o
);

  logic [lkv_pkg::LimitBits-1:0] entry_limit_q;
  logic [lkv_pkg::CountBits-1:0] eff_limit;
  logic                          req_valid, req_ready;
  lkv_pkg::req_t                 req;
  lkv_pkg::rsp_t                 rsp;
  lkv_pkg::status_t              status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q <= lkv_pkg::LimitReset;
    end else if (cfg_we_i) begin
      entry_limit_q <= cfg_wdata_i;
    end
  end

  // The limit is clamped to the range one through the table size.
  always_comb begin
    if (entry_limit_q == '0) begin
      eff_limit = lkv_pkg::CountBits'(1);
    end else if (32'(entry_limit_q) > lkv_pkg::MaxEntries) begin
      eff_limit = lkv_pkg::CountBits'(lkv_pkg::MaxEntries);
    end else begin
      eff_limit = lkv_pkg::CountBits'(entry_limit_q);
    end
  end

  lkv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  lkv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .limit_i     (eff_limit),
    .pop_i       (pop),
    .empty_o     (empty),
    .rsp_o       (rsp),
    .status_o    (status)
  );

  assign hit_o        = rsp.hit;
  assign read_value_o = rsp.value;

  // The fill count always matches the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(status.valid) == 32'(status.used))
    else $error("fill count does not match valid entries");

  // A request taken by the back end leaves a result to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !empty)
    else $error("dispatched request left no result");

  // The fill count only ever grows, and by one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.used != $past(status.used)) |->
      (status.used == $past(status.used) + lkv_pkg::CountBits'(1)))
    else $error("fill count moved by other than one");

endmodule

// ----- rtl/lkv_front.sv -----
// Request front end of the LRU key-value cache: decodes incoming requests
// and holds them in a two-entry queue for the back end.
// Depends on lkv_pkg.
module lkv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          command_i,
  input  logic [lkv_pkg::KeyBits-1:0]   key_i,
  input  logic [lkv_pkg::ValueBits-1:0] write_value_i,
  output logic                          req_valid_o,
  input  logic                          req_ready_i,
  output lkv_pkg::req_t                 req_o
);

  lkv_pkg::req_t                  mem_q [lkv_pkg::QueueDepth];
  logic [lkv_pkg::QPtrBits-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lkv_pkg::QCntBits-1:0]   count_q, count_d;
  lkv_pkg::req_t                  new_req;
  logic                           wr_en, rd_en;

  always_comb begin
    new_req.cmd   = command_i ? lkv_pkg::CmdStore : lkv_pkg::CmdLookup;
    new_req.key   = key_i;
    new_req.value = write_value_i;
  end

  assign full_o      = (count_q == lkv_pkg::QCntBits'(lkv_pkg::QueueDepth));
  assign req_valid_o = (count_q != '0);
  assign req_o       = mem_q[rptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = req_valid_o && req_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr_en) begin
      wptr_d = (wptr_q == lkv_pkg::QPtrBits'(lkv_pkg::QueueDepth - 1)) ? '0
             : wptr_q + lkv_pkg::QPtrBits'(1);
    end
    if (rd_en) begin
      rptr_d = (rptr_q == lkv_pkg::QPtrBits'(lkv_pkg::QueueDepth - 1)) ? '0
             : rptr_q + lkv_pkg::QPtrBits'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + lkv_pkg::QCntBits'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - lkv_pkg::QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= new_req;
    end
  end

endmodule

// ----- rtl/lkv_back.sv -----
// Cache back end of the LRU key-value cache: tag table, recency ranks,
// replacement, and a two-entry result queue toward the output side.
// Depends on lkv_pkg.
module lkv_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  lkv_pkg::req_t                 req_i,
  input  logic [lkv_pkg::CountBits-1:0] limit_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output lkv_pkg::rsp_t                 rsp_o,
  output lkv_pkg::status_t              status_o
);

  // Cache table.
  logic [lkv_pkg::KeyBits-1:0]   key_q  [lkv_pkg::MaxEntries];
  logic [lkv_pkg::ValueBits-1:0] val_q  [lkv_pkg::MaxEntries];
  logic [lkv_pkg::IdxBits-1:0]   rank_q [lkv_pkg::MaxEntries];
  logic [lkv_pkg::IdxBits-1:0]   rank_d [lkv_pkg::MaxEntries];
  logic [lkv_pkg::MaxEntries-1:0] valid_q, valid_d;
  logic [lkv_pkg::CountBits-1:0]  used_q, used_d;

  // Result queue.
  lkv_pkg::rsp_t                rsp_mem_q [lkv_pkg::QueueDepth];
  logic [lkv_pkg::QPtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lkv_pkg::QCntBits-1:0] count_q, count_d;

  logic                          fire, hit, has_free, fill, update, is_store;
  logic [lkv_pkg::MaxEntries-1:0] match, victim;
  logic [lkv_pkg::IdxBits-1:0]   found_idx, free_idx, victim_idx, target_idx;
  logic [lkv_pkg::IdxBits-1:0]   target_rank;
  logic [lkv_pkg::CountBits-1:0] oldest_rank;
  lkv_pkg::rsp_t                 new_rsp;
  logic                          rsp_pop;

  assign req_ready_o = (count_q != lkv_pkg::QCntBits'(lkv_pkg::QueueDepth));
  assign fire        = req_valid_i && req_ready_o;
  assign is_store    = (req_i.cmd == lkv_pkg::CmdStore);
  assign oldest_rank = used_q - lkv_pkg::CountBits'(1);

  // Parallel tag compare and the three priority picks, lowest index first.
  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = lkv_pkg::MaxEntries - 1; i >= 0; i--) begin
      match[i]  = valid_q[i] && (key_q[i] == req_i.key);
      victim[i] = valid_q[i] && (lkv_pkg::CountBits'(rank_q[i]) == oldest_rank);
      if (match[i]) begin
        found_idx = lkv_pkg::IdxBits'(i);
      end
      if (!valid_q[i]) begin
        free_idx = lkv_pkg::IdxBits'(i);
      end
      if (victim[i]) begin
        victim_idx = lkv_pkg::IdxBits'(i);
      end
    end
  end

  assign hit      = |match;
  assign has_free = ~&valid_q;
  assign fill     = is_store && !hit && (used_q < limit_i) && has_free;
  assign update   = fire && (hit || is_store);

  always_comb begin
    if (hit) begin
      target_idx = found_idx;
    end else if (fill) begin
      target_idx = free_idx;
    end else begin
      target_idx = victim_idx;
    end
  end

  assign target_rank = rank_q[target_idx];

  // Recency update: a fill ages every valid entry, a promotion ages only
  // the entries newer than the target.
  always_comb begin
    valid_d = valid_q;
    used_d  = used_q;
    for (int i = 0; i < lkv_pkg::MaxEntries; i++) begin
      rank_d[i] = rank_q[i];
      if (update && valid_q[i] && (lkv_pkg::IdxBits'(i) != target_idx) &&
          (fill || (rank_q[i] < target_rank))) begin
        rank_d[i] = rank_q[i] + lkv_pkg::IdxBits'(1);
      end
    end
    if (update) begin
      rank_d[target_idx] = '0;
    end
    if (fire && fill) begin
      valid_d[free_idx] = 1'b1;
      used_d            = used_q + lkv_pkg::CountBits'(1);
    end
  end

  always_comb begin
    new_rsp.hit   = hit;
    new_rsp.value = (!is_store && hit) ? val_q[found_idx] : '0;
  end

  assign empty_o  = (count_q == '0);
  assign rsp_o    = rsp_mem_q[rptr_q];
  assign rsp_pop  = pop_i && !empty_o;
  assign status_o = '{valid: valid_q, used: used_q};

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (fire) begin
      wptr_d = (wptr_q == lkv_pkg::QPtrBits'(lkv_pkg::QueueDepth - 1)) ? '0
             : wptr_q + lkv_pkg::QPtrBits'(1);
    end
    if (rsp_pop) begin
      rptr_d = (rptr_q == lkv_pkg::QPtrBits'(lkv_pkg::QueueDepth - 1)) ? '0
             : rptr_q + lkv_pkg::QPtrBits'(1);
    end
    if (fire && !rsp_pop) begin
      count_d = count_q + lkv_pkg::QCntBits'(1);
    end else if (rsp_pop && !fire) begin
      count_d = count_q - lkv_pkg::QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      for (int i = 0; i < lkv_pkg::MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
      for (int i = 0; i < lkv_pkg::MaxEntries; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_store) begin
      val_q[target_idx] <= req_i.value;
      if (!hit) begin
        key_q[target_idx] <= req_i.key;
      end
    end
    if (fire) begin
      rsp_mem_q[wptr_q] <= new_rsp;
    end
  end

endmodule
